/* src/bfdh_pkg.sv */
// ----------------------------------------------------------------------------
// Bloom filter double-hash package
// Shared constants, action codes and state type for the Bloom filter engine.
// ----------------------------------------------------------------------------
package bfdh_pkg;

    localparam int MAX_BITS   = 65536;
    localparam int MAX_PROBES = 32;
    localparam int ROW_W      = 32;
    localparam int ROWS       = MAX_BITS / ROW_W;
    localparam int ROW_AW     = $clog2(ROWS);
    localparam int COL_W      = $clog2(ROW_W);
    localparam int POS_W      = $clog2(MAX_BITS);

    localparam int BITCNT_W   = 17;
    localparam int PROBES_W   = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [BITCNT_W-1:0] BITCNT_RST = BITCNT_W'(1024);
    localparam logic [PROBES_W-1:0] PROBES_RST = PROBES_W'(3);
    localparam logic [BITCNT_W-1:0] BITCNT_MAX = BITCNT_W'(MAX_BITS);
    localparam logic [PROBES_W-1:0] PROBES_MAX = PROBES_W'(MAX_PROBES);

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_RSVD  = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_COUNT   = 1'b0,
        CFG_PROBE_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX,
        ST_DIV,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

/* src/bfdh_if.sv */
// ----------------------------------------------------------------------------
// Bloom filter channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfdh_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] hash_std;
    logic [63:0] hash_fnv;
    modport source (output valid, action, hash_std, hash_fnv, input ready);
    modport sink   (input valid, action, hash_std, hash_fnv, output ready);
endinterface

interface bfdh_rsp_if;
    logic       valid;
    logic       ready;
    logic       maybe_present;
    logic [1:0] done_action;
    modport source (output valid, maybe_present, done_action, input ready);
    modport sink   (input valid, maybe_present, done_action, output ready);
endinterface

interface bfdh_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [16:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/bfdh_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle (a read, with an optional write), read data registered.
// ----------------------------------------------------------------------------
module bfdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bloom_filter_double_hash_unit.sv */
// ----------------------------------------------------------------------------
// Bloom filter double-hash unit
// Usage:
//   i_req carries one request: action (clear, add, query), and two raw 64-bit
//   key digests. o_rsp returns one response per request: maybe_present and the
//   echoed action. i_cfg writes bit_count (index 0) and probe_count (index 1);
//   it is always ready. It must be written only while the unit is idle; the
//   unit does not enforce this. Both digests are finalized on one shared
//   32x32 multiplier. Each probe then runs an 8-bit-per-cycle remainder unit
//   and a read, plus a write for an add, on the 2048x32 filter RAM. A query
//   stops at the first clear bit. A reserved action or zero probes goes
//   straight to the response. A clear sweeps the RAM, one row a cycle.
//   After reset the same sweep runs and no request is taken.
//   The response sits in an output register: a new request is taken while it
//   waits, and the unit holds the next response until the receiver takes it.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfdh_req_if.sink   i_req,
    bfdh_rsp_if.source o_rsp,
    bfdh_cfg_if.sink   i_cfg
);
    import bfdh_pkg::*;

    t_state               r_state, n_state;
    logic [1:0]           r_act, n_act;
    logic [63:0]          r_fnv, n_fnv;
    logic [63:0]          r_a, n_a;
    logic [63:0]          r_acc, n_acc;
    logic [63:0]          r_prod, n_prod;
    logic [1:0]           r_mph, n_mph;
    logic [1:0]           r_mstep, n_mstep;
    logic [63:0]          r_stride, n_stride;
    logic [63:0]          r_x, n_x;
    logic [63:0]          r_q, n_q;
    logic [BITCNT_W-1:0]  r_rem, n_rem;
    logic [2:0]           r_dcnt, n_dcnt;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [PROBES_W-1:0]  r_i, n_i;
    logic                 r_hit, n_hit;
    logic                 r_item, n_item;
    logic [ROW_AW-1:0]    r_caddr, n_caddr;
    logic                 r_ovalid, n_ovalid;
    logic                 r_omay, n_omay;
    logic [1:0]           r_oact, n_oact;
    logic [BITCNT_W-1:0]  r_bitcnt;
    logic [PROBES_W-1:0]  r_probes;

    logic [BITCNT_W-1:0]  w_mod;
    logic [PROBES_W-1:0]  w_k;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_bit;
    logic                 w_last;
    logic [63:0]          w_c;
    logic [31:0]          w_op_a, w_op_c;
    logic [63:0]          w_mul;
    logic [63:0]          w_sum;
    logic [63:0]          w_mixed;
    logic [BITCNT_W-1:0]  w_rem;
    logic [63:0]          w_q;

    logic                 w_ram_we;
    logic [ROW_AW-1:0]    w_ram_addr;
    logic [ROW_W-1:0]     w_ram_wdata;
    logic [ROW_W-1:0]     w_ram_rdata;

    bfdh_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // Effective modulus and probe count.
    always_comb begin
        if (r_bitcnt == '0) begin
            w_mod = BITCNT_W'(1);
        end else if (r_bitcnt > BITCNT_MAX) begin
            w_mod = BITCNT_MAX;
        end else begin
            w_mod = r_bitcnt;
        end
        w_k = (r_probes > PROBES_MAX) ? PROBES_MAX : r_probes;
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_ovalid || o_rsp.ready;

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.maybe_present = r_omay;
    assign o_rsp.done_action   = r_oact;

    // Shared multiplier: the three partial products that form the low 64 bits.
    assign w_c    = r_mph[0] ? MIX_C2 : MIX_C1;
    assign w_op_a = (r_mstep == 2'd2) ? r_a[63:32] : r_a[31:0];
    assign w_op_c = (r_mstep == 2'd1) ? w_c[63:32] : w_c[31:0];
    assign w_mul  = {32'b0, w_op_a} * {32'b0, w_op_c};
    assign w_sum  = r_acc + {r_prod[31:0], 32'b0};
    assign w_mixed = w_sum ^ (w_sum >> 33);

    // Eight restoring remainder steps, one dividend bit each.
    always_comb begin
        logic [BITCNT_W:0] t;
        w_rem = r_rem;
        w_q   = r_q;
        for (int j = 0; j < 8; j++) begin
            t = {w_rem, w_q[63]};
            if (t >= {1'b0, w_mod}) begin
                t = t - {1'b0, w_mod};
            end
            w_rem = t[BITCNT_W-1:0];
            w_q   = {w_q[62:0], 1'b0};
        end
    end

    assign w_bit  = w_ram_rdata[r_pos[COL_W-1:0]];
    assign w_last = ((r_i + PROBES_W'(1)) == w_k);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_caddr == ROW_AW'(ROWS - 1)) begin
                    n_state = r_item ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.action == ACT_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (i_req.action == ACT_RSVD || w_k == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_MIX;
                    end
                end
            end
            ST_MIX: begin
                if (r_mstep == 2'd3 && r_mph == 2'd3) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_dcnt == 3'd7) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_CHECK;
            ST_CHECK: begin
                if ((r_act == ACT_QUERY && !w_bit) || w_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // RAM port control.
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_addr  = r_pos[POS_W-1:COL_W];
        w_ram_wdata = w_ram_rdata | (ROW_W'(1) << r_pos[COL_W-1:0]);
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_caddr;
                w_ram_wdata = '0;
            end
            ST_CHECK: w_ram_we = (r_act == ACT_ADD);
            default: w_ram_we = 1'b0;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_act    = r_act;
        n_fnv    = r_fnv;
        n_a      = r_a;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_mph    = r_mph;
        n_mstep  = r_mstep;
        n_stride = r_stride;
        n_x      = r_x;
        n_q      = r_q;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_pos    = r_pos;
        n_i      = r_i;
        n_hit    = r_hit;
        n_item   = r_item;
        n_caddr  = r_caddr;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_omay   = r_omay;
        n_oact   = r_oact;

        unique case (r_state)
            ST_CLEAR: begin
                n_caddr = r_caddr + ROW_AW'(1);
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_act   = i_req.action;
                    n_fnv   = i_req.hash_fnv;
                    n_a     = i_req.hash_std ^ (i_req.hash_std >> 33);
                    n_mph   = 2'd0;
                    n_mstep = 2'd0;
                    n_i     = '0;
                    n_item  = 1'b1;
                    n_caddr = '0;
                    n_hit   = (i_req.action == ACT_QUERY);
                end
            end
            ST_MIX: begin
                n_prod  = w_mul;
                n_mstep = r_mstep + 2'd1;
                if (r_mstep == 2'd1) begin
                    n_acc = r_prod;
                end else if (r_mstep == 2'd2) begin
                    n_acc = w_sum;
                end else if (r_mstep == 2'd3) begin
                    n_mph = r_mph + 2'd1;
                    unique case (r_mph)
                        2'd0: n_a = w_mixed;
                        // First digest finished: it is the probe base.
                        2'd1: begin
                            n_x = w_mixed;
                            n_a = r_fnv ^ (r_fnv >> 33);
                        end
                        2'd2: n_a = w_mixed;
                        default: begin
                            n_stride = w_mixed | 64'd1;
                            n_q      = r_x;
                            n_rem    = '0;
                            n_dcnt   = '0;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_rem  = w_rem;
                n_q    = w_q;
                n_dcnt = r_dcnt + 3'd1;
                if (r_dcnt == 3'd7) begin
                    n_pos = w_rem[POS_W-1:0];
                end
            end
            ST_CHECK: begin
                if (r_act == ACT_QUERY && !w_bit) begin
                    n_hit = 1'b0;
                end else if (!w_last) begin
                    n_x    = r_x + r_stride;
                    n_q    = r_x + r_stride;
                    n_rem  = '0;
                    n_dcnt = '0;
                    n_i    = r_i + PROBES_W'(1);
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_omay   = r_hit;
                    n_oact   = r_act;
                    n_item   = 1'b0;
                end
            end
            default: n_item = r_item;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_item   <= 1'b0;
            r_caddr  <= '0;
            r_ovalid <= 1'b0;
            r_bitcnt <= BITCNT_RST;
            r_probes <= PROBES_RST;
        end else begin
            r_state  <= n_state;
            r_item   <= n_item;
            r_caddr  <= n_caddr;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_BIT_COUNT:   r_bitcnt <= i_cfg.data;
                    CFG_PROBE_COUNT: r_probes <= i_cfg.data[PROBES_W-1:0];
                    default:         r_bitcnt <= r_bitcnt;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_fnv    <= n_fnv;
        r_a      <= n_a;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_mph    <= n_mph;
        r_mstep  <= n_mstep;
        r_stride <= n_stride;
        r_x      <= n_x;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_dcnt   <= n_dcnt;
        r_pos    <= n_pos;
        r_i      <= n_i;
        r_hit    <= n_hit;
        r_omay   <= n_omay;
        r_oact   <= n_oact;
    end

endmodule
